// ===== hdl/contact_pair_event_tracker_macros.svh =====
// Assertion macros shared by the contact pair event tracker RTL.
// Needs clk and arst_n in the scope of every use.
`ifndef CONTACT_PAIR_EVENT_TRACKER_MACROS_SVH
`define CONTACT_PAIR_EVENT_TRACKER_MACROS_SVH

// Same-cycle implication, off while in reset.
`define CPET_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("contact pair tracker: implication failed");

// Next-cycle implication, off while in reset.
`define CPET_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("contact pair tracker: next-cycle check failed");

`endif

// ===== hdl/cpet_pkg.sv =====
// Shared constants of the contact pair event tracker: command and result codes,
// field widths and register addresses. No dependencies.
package cpet_pkg;
	localparam int BODY_W = 10;
	localparam int CMD_W  = 3;
	localparam int KIND_W = 3;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 24;
	localparam int PADDR_W = 3;

	localparam logic [CMD_W-1:0] CMD_TOUCH       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_END_STEP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DISARM_ALL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISARM_BODY = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DROP_BODY   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET_FLAGS   = 3'd5;

	localparam logic [KIND_W-1:0] KIND_BEGIN = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STAY  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DONE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FULL  = 3'd4;

	localparam logic [PADDR_W-1:0] ADDR_EVENTS_ENABLED   = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_LISTENER_PRESENT = 3'd4;
endpackage

// ===== hdl/contact_pair_event_tracker.sv =====
// Contact pair event tracker, top level.
// Depends on cpet_pkg, cpet_ram and contact_pair_event_tracker_macros.svh.
//
// Keeps up to PAIR_CAPACITY body pairs in contact and reports Begin, Stay and
// End events, Full when no pair RAM entry is free and Done when an end of
// step has no End to report. Pair keys live in a pair RAM; per-body flags
// (event on, sensor) live in a body RAM of MAX_BODIES words. After reset the
// block sweeps the body RAM and accepts no item meanwhile (register writes are
// taken). Item steps, from the accept cycle up to the next cycle with s_tready
// high: quiet commands (disarm all, set body flags, dead touch, unused codes)
// end in their accept cycle; a touch scans the pair RAM one entry per cycle up
// to a hit or the end of the table, then reads the flags of both bodies;
// disarm body and drop body scan the whole pair RAM; end of step marks entries
// in its accept cycle, then for each removed armed pair runs one full pair RAM
// scan and a flag read to emit Ends in ascending (low, high) order, and a final
// scan that emits the last result. The single read port of each RAM makes
// these scans and reads go one entry at a time. A full output register holds
// the sequencer in a state that would emit, and at the end of every live touch;
// a final result that sits in the output register does not hold the next item.
module contact_pair_event_tracker #(
	parameter int PAIR_CAPACITY = 64,
	parameter int MAX_BODIES    = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// s_tdata: body_a[9:0], body_b[19:10], both_alive[20],
	// flag_events_on[21], flag_sensor[22], zeros above
	// s_tuser: command[2:0]
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cpet_pkg::IN_W-1:0]    s_tdata,
	input  logic [cpet_pkg::CMD_W-1:0]   s_tuser,
	// m_tdata: body_low[9:0], body_high[19:10], is_sensor[20], zeros above
	// m_tuser: event_kind[2:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cpet_pkg::OUT_W-1:0]   m_tdata,
	output logic [cpet_pkg::KIND_W-1:0]  m_tuser,
	output logic                         m_tlast,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cpet_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import cpet_pkg::*;

	localparam int IW = $clog2(PAIR_CAPACITY);
	localparam int CW = IW + 1;
	localparam int BW = $clog2(MAX_BODIES);
	localparam int KW = 2 * BODY_W;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_T_SCAN = 4'd2;
	localparam logic [3:0] ST_T_F0   = 4'd3;
	localparam logic [3:0] ST_T_F1   = 4'd4;
	localparam logic [3:0] ST_T_F2   = 4'd5;
	localparam logic [3:0] ST_B_SCAN = 4'd6;
	localparam logic [3:0] ST_E_SCAN = 4'd7;
	localparam logic [3:0] ST_E_F0   = 4'd8;
	localparam logic [3:0] ST_E_F1   = 4'd9;
	localparam logic [3:0] ST_E_F2   = 4'd10;

	// Configuration registers
	logic ev_en_q, listen_q;
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_en_q  <= 1'b1;
			listen_q <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr == ADDR_EVENTS_ENABLED) ev_en_q <= pwdata[0];
			if (paddr == ADDR_LISTENER_PRESENT) listen_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == ADDR_EVENTS_ENABLED) prdata[0] = ev_en_q;
		if (paddr == ADDR_LISTENER_PRESENT) prdata[0] = listen_q;
	end

	// Input fields
	logic [CMD_W-1:0]  in_cmd;
	logic [BODY_W-1:0] in_a, in_b;
	logic              in_alive, in_ev, in_sens, in_acc;
	assign in_cmd   = s_tuser;
	assign in_a     = s_tdata[9:0];
	assign in_b     = s_tdata[19:10];
	assign in_alive = s_tdata[20];
	assign in_ev    = s_tdata[21];
	assign in_sens  = s_tdata[22];

	logic [3:0] state_q;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;

	// Per-entry flags in flip-flops
	logic [PAIR_CAPACITY-1:0] valid_q, armed_q, touched_q, cand_q;

	// Working registers
	logic [BODY_W-1:0] lo_q, hi_q, body_q;
	logic              drop_q, new_q, full_q;
	logic [IW-1:0]     slot_q;
	logic [CW-1:0]     cnt_q;
	logic              rv_s1;
	logic [IW-1:0]     ri_s1;
	logic [BW-1:0]     clr_q;
	logic [1:0]        fl_lo_q;
	logic              best_found_q;
	logic [KW-1:0]     best_key_q;
	logic [IW-1:0]     best_idx_q;
	logic              pend_q, pend_sens_q;
	logic [BODY_W-1:0] pend_lo_q, pend_hi_q;

	// Pair RAM: {low body, high body}
	logic          pr_we;
	logic [KW-1:0] pr_rd;
	cpet_ram #(.WIDTH(KW), .DEPTH(PAIR_CAPACITY)) u_pair_ram (
		.clk(clk), .we(pr_we), .waddr(slot_q), .wdata({lo_q, hi_q}),
		.raddr(cnt_q[IW-1:0]), .rdata(pr_rd)
	);

	// Body RAM: {event on, sensor}
	logic          br_we;
	logic [BW-1:0] br_waddr, br_raddr;
	logic [1:0]    br_wdata, br_rd;
	cpet_ram #(.WIDTH(2), .DEPTH(MAX_BODIES)) u_body_ram (
		.clk(clk), .we(br_we), .waddr(br_waddr), .wdata(br_wdata),
		.raddr(br_raddr), .rdata(br_rd)
	);

	logic lo_inr, hi_inr;
	assign lo_inr = (32'(lo_q) < MAX_BODIES);
	assign hi_inr = (32'(hi_q) < MAX_BODIES);

	// Sweep after reset, else set body flags on accept
	always_comb begin
		br_we    = 1'b0;
		br_waddr = clr_q;
		br_wdata = 2'b10;
		if (state_q == ST_CLEAR) begin
			br_we = 1'b1;
		end else if (in_acc && in_cmd == CMD_SET_FLAGS && 32'(in_a) < MAX_BODIES) begin
			br_we    = 1'b1;
			br_waddr = BW'(in_a);
			br_wdata = {in_ev, in_sens};
		end
	end
	assign br_raddr = (state_q == ST_T_F0 || state_q == ST_E_F0) ? BW'(lo_q) : BW'(hi_q);

	// Flags of the pair once both reads are back (valid in the F2 states)
	logic on_lo, on_hi, sens_pair, gated;
	assign on_lo     = lo_inr ? fl_lo_q[1] : 1'b1;
	assign on_hi     = hi_inr ? br_rd[1] : 1'b1;
	assign sens_pair = (lo_inr & fl_lo_q[0]) | (hi_inr & br_rd[0]);
	assign gated     = !ev_en_q || !on_lo || !on_hi;

	// Scan control
	logic scan_st, issue, scan_end, match;
	assign scan_st  = (state_q == ST_T_SCAN) || (state_q == ST_B_SCAN)
		|| (state_q == ST_E_SCAN);
	assign issue    = scan_st && (cnt_q < CW'(PAIR_CAPACITY));
	assign scan_end = (cnt_q == CW'(PAIR_CAPACITY)) && !rv_s1;
	assign match    = rv_s1 && valid_q[ri_s1] && (pr_rd == {lo_q, hi_q});

	// Lowest free entry
	logic          free_found;
	logic [IW-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = PAIR_CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// Output register
	logic              out_free, emit, e_sens, e_last;
	logic [KIND_W-1:0] e_kind;
	logic [BODY_W-1:0] e_lo, e_hi;
	logic              mv_q, ml_q;
	logic [OUT_W-1:0]  md_q;
	logic [KIND_W-1:0] mk_q;
	assign out_free = !mv_q || m_tready;
	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;
	assign m_tuser  = mk_q;
	assign m_tlast  = ml_q;
	assign pr_we    = (state_q == ST_T_F2) && out_free && !full_q && new_q;

	always_comb begin
		emit   = 1'b0;
		e_kind = KIND_DONE;
		e_lo   = '0;
		e_hi   = '0;
		e_sens = 1'b0;
		e_last = 1'b1;
		case (state_q)
			ST_T_F2: begin
				e_lo   = lo_q;
				e_hi   = hi_q;
				e_sens = sens_pair;
				if (full_q) begin
					emit   = out_free;
					e_kind = KIND_FULL;
				end else if (!gated && listen_q) begin
					emit   = out_free;
					e_kind = (!new_q && armed_q[slot_q]) ? KIND_STAY : KIND_BEGIN;
				end
			end
			ST_E_SCAN: begin
				if (scan_end && !best_found_q) begin
					emit = out_free;
					if (pend_q) begin
						e_kind = KIND_END;
						e_lo   = pend_lo_q;
						e_hi   = pend_hi_q;
						e_sens = pend_sens_q;
					end
				end
			end
			ST_E_F2: begin
				if (!gated && pend_q) begin
					emit   = out_free;
					e_kind = KIND_END;
					e_lo   = pend_lo_q;
					e_hi   = pend_hi_q;
					e_sens = pend_sens_q;
					e_last = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (emit) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			md_q <= OUT_W'({e_sens, e_hi, e_lo});
			mk_q <= e_kind;
			ml_q <= e_last;
		end
	end

	// Main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			valid_q      <= '0;
			armed_q      <= '0;
			touched_q    <= '0;
			cand_q       <= '0;
			cnt_q        <= '0;
			rv_s1        <= 1'b0;
			new_q        <= 1'b0;
			full_q       <= 1'b0;
			drop_q       <= 1'b0;
			pend_q       <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (32'(clr_q) == MAX_BODIES - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						case (in_cmd)
							CMD_TOUCH: begin
								if (in_alive) begin
									state_q <= ST_T_SCAN;
								end
							end
							CMD_END_STEP: begin
								// Pick removed armed pairs, drop untouched entries
								cand_q    <= valid_q & ~touched_q & armed_q
									& {PAIR_CAPACITY{listen_q}};
								armed_q   <= armed_q & touched_q & valid_q;
								valid_q   <= valid_q & touched_q;
								touched_q <= '0;
								pend_q       <= 1'b0;
								best_found_q <= 1'b0;
								state_q      <= ST_E_SCAN;
							end
							CMD_DISARM_ALL: armed_q <= '0;
							CMD_DISARM_BODY, CMD_DROP_BODY: begin
								drop_q  <= (in_cmd == CMD_DROP_BODY);
								state_q <= ST_B_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_T_SCAN: begin
					if (match) begin
						new_q   <= 1'b0;
						full_q  <= 1'b0;
						slot_q  <= ri_s1;
						state_q <= ST_T_F0;
					end else if (scan_end) begin
						new_q   <= free_found;
						full_q  <= !free_found;
						slot_q  <= free_idx;
						state_q <= ST_T_F0;
					end
				end
				ST_T_F0: state_q <= ST_T_F1;
				ST_T_F1: begin
					fl_lo_q <= br_rd;
					state_q <= ST_T_F2;
				end
				ST_T_F2: begin
					if (out_free) begin
						if (!full_q) begin
							valid_q[slot_q]   <= 1'b1;
							touched_q[slot_q] <= 1'b1;
							armed_q[slot_q]   <= !gated;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_B_SCAN: begin
					if (rv_s1 && valid_q[ri_s1]
						&& (pr_rd[KW-1:BODY_W] == body_q || pr_rd[BODY_W-1:0] == body_q)) begin
						armed_q[ri_s1] <= 1'b0;
						if (drop_q) begin
							valid_q[ri_s1]   <= 1'b0;
							touched_q[ri_s1] <= 1'b0;
						end
					end
					if (scan_end) state_q <= ST_IDLE;
				end
				ST_E_SCAN: begin
					// Track the smallest key among remaining candidates
					if (rv_s1 && cand_q[ri_s1]
						&& (!best_found_q || pr_rd < best_key_q)) begin
						best_found_q <= 1'b1;
						best_key_q   <= pr_rd;
						best_idx_q   <= ri_s1;
					end
					if (scan_end) begin
						if (best_found_q) begin
							cand_q[best_idx_q] <= 1'b0;
							state_q <= ST_E_F0;
						end else if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_E_F0: state_q <= ST_E_F1;
				ST_E_F1: begin
					fl_lo_q <= br_rd;
					state_q <= ST_E_F2;
				end
				ST_E_F2: begin
					// Hold one End back so the final one can carry last
					if (gated || !pend_q || out_free) begin
						if (!gated) begin
							pend_q      <= 1'b1;
							pend_lo_q   <= lo_q;
							pend_hi_q   <= hi_q;
							pend_sens_q <= sens_pair;
						end
						cnt_q        <= '0;
						best_found_q <= 1'b0;
						state_q      <= ST_E_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		ri_s1 <= cnt_q[IW-1:0];
		if (in_acc) begin
			body_q <= in_a;
			lo_q   <= (in_a < in_b) ? in_a : in_b;
			hi_q   <= (in_a < in_b) ? in_b : in_a;
		end else if (state_q == ST_E_SCAN && scan_end && best_found_q) begin
			lo_q <= best_key_q[KW-1:BODY_W];
			hi_q <= best_key_q[BODY_W-1:0];
		end
	end

	`include "contact_pair_event_tracker_macros.svh"

	`CPET_ASSERT_IMP(a_emit_free, emit, !mv_q || m_tready)
	`CPET_ASSERT_IMP(a_touched_valid, 1'b1, (touched_q & ~valid_q) == '0)
	`CPET_ASSERT_IMP(a_armed_valid, 1'b1, (armed_q & ~valid_q) == '0)
	`CPET_ASSERT_NXT(a_hit_no_write, state_q == ST_T_SCAN && match, !pr_we)
endmodule

// ===== hdl/cpet_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cpet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for contact_pair_event_tracker: random and directed command
// items, an in-bench pair table predictor and a scoreboard of expected event items.
// Depends on cpet_pkg and the RTL top level.
`timescale 1ns / 1ps

typedef struct packed {
	logic [2:0] kind;
	logic [9:0] low;
	logic [9:0] high;
	logic       sens;
	logic       last;
} contact_event_t;

class pair_event_scoreboard;
	contact_event_t events_due[$];
	int             errors;
	bit             events_enabled;
	bit             listener_present;
	bit             valid[64];
	bit [9:0]       lo_body[64];
	bit [9:0]       hi_body[64];
	bit             armed[64];
	bit             touched[64];
	bit             ev_on[1024];
	bit             sensor[1024];

	function new();
		errors = 0;
		events_enabled = 1;
		listener_present = 1;
		foreach (valid[i]) begin
			valid[i] = 0;
			armed[i] = 0;
			touched[i] = 0;
		end
		foreach (ev_on[i]) begin
			ev_on[i] = 1;
			sensor[i] = 0;
		end
	endfunction

	function void set_config(logic [2:0] addr, logic [31:0] value);
		if (addr == cpet_pkg::ADDR_EVENTS_ENABLED)
			events_enabled = value[0];
		else if (addr == cpet_pkg::ADDR_LISTENER_PRESENT)
			listener_present = value[0];
	endfunction

	function bit gated(bit [9:0] lo, bit [9:0] hi);
		return !events_enabled || !ev_on[lo] || !ev_on[hi];
	endfunction

	function void push(bit [2:0] kind, bit [9:0] lo, bit [9:0] hi, bit s, bit l);
		contact_event_t e;
		e.kind = kind;
		e.low = lo;
		e.high = hi;
		e.sens = s;
		e.last = l;
		events_due = {events_due, e};
	endfunction

	// Run the pair table forward by one accepted command item.
	function void note_item(logic [23:0] d, logic [2:0] u);
		bit [2:0] cmd;
		bit [9:0] a, b, lo, hi;
		int       slot;
		bit       s;
		int       keys[$];
		cmd = u;
		a = d[9:0];
		b = d[19:10];
		case (cmd)
			cpet_pkg::CMD_TOUCH: begin
				if (!d[20])
					return;
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
				s = sensor[lo] | sensor[hi];
				slot = -1;
				for (int i = 0; i < 64; i++)
					if (slot < 0 && valid[i] && lo_body[i] == lo && hi_body[i] == hi)
						slot = i;
				if (slot < 0) begin
					for (int i = 0; i < 64; i++)
						if (slot < 0 && !valid[i])
							slot = i;
					if (slot < 0) begin
						push(cpet_pkg::KIND_FULL, lo, hi, s, 1'b1);
						return;
					end
					valid[slot] = 1;
					lo_body[slot] = lo;
					hi_body[slot] = hi;
					armed[slot] = 0;
				end
				touched[slot] = 1;
				if (gated(lo, hi)) begin
					armed[slot] = 0;
				end else if (!armed[slot]) begin
					armed[slot] = 1;
					if (listener_present)
						push(cpet_pkg::KIND_BEGIN, lo, hi, s, 1'b1);
				end else if (listener_present) begin
					push(cpet_pkg::KIND_STAY, lo, hi, s, 1'b1);
				end
			end
			cpet_pkg::CMD_END_STEP: begin
				for (int i = 0; i < 64; i++) begin
					if (valid[i]) begin
						if (touched[i]) begin
							touched[i] = 0;
						end else begin
							if (armed[i] && listener_present && !gated(lo_body[i], hi_body[i]))
								keys = {keys, 32'({lo_body[i], hi_body[i]})};
							valid[i] = 0;
							armed[i] = 0;
						end
					end
				end
				if (keys.size() == 0) begin
					push(cpet_pkg::KIND_DONE, 10'd0, 10'd0, 1'b0, 1'b1);
				end else begin
					keys.sort();
					foreach (keys[k]) begin
						lo = keys[k][19:10];
						hi = keys[k][9:0];
						push(cpet_pkg::KIND_END, lo, hi, sensor[lo] | sensor[hi],
							k == keys.size() - 1);
					end
				end
			end
			cpet_pkg::CMD_DISARM_ALL: begin
				foreach (armed[i])
					armed[i] = 0;
			end
			cpet_pkg::CMD_DISARM_BODY: begin
				for (int i = 0; i < 64; i++)
					if (valid[i] && (lo_body[i] == a || hi_body[i] == a))
						armed[i] = 0;
			end
			cpet_pkg::CMD_DROP_BODY: begin
				for (int i = 0; i < 64; i++)
					if (valid[i] && (lo_body[i] == a || hi_body[i] == a)) begin
						valid[i] = 0;
						armed[i] = 0;
						touched[i] = 0;
					end
			end
			cpet_pkg::CMD_SET_FLAGS: begin
				ev_on[a] = d[21];
				sensor[a] = d[22];
			end
			default: ;
		endcase
	endfunction

	function void check_result(logic [23:0] d, logic [2:0] u, logic l);
		contact_event_t e;
		if (events_due.size() == 0) begin
			$error("unexpected event item %h kind %0d last %b", d, u, l);
			errors++;
			return;
		end
		e = events_due.pop_front();
		if (u !== e.kind) begin
			$error("event_kind expected %0d actual %0d", e.kind, u);
			errors++;
		end
		if (d[9:0] !== e.low) begin
			$error("body_low expected %0d actual %0d", e.low, d[9:0]);
			errors++;
		end
		if (d[19:10] !== e.high) begin
			$error("body_high expected %0d actual %0d", e.high, d[19:10]);
			errors++;
		end
		if (d[20] !== e.sens) begin
			$error("is_sensor expected %0d actual %0d", e.sens, d[20]);
			errors++;
		end
		if (l !== e.last) begin
			$error("last expected %0d actual %0d", e.last, l);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import cpet_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              s_tvalid = 0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic [CMD_W-1:0]  s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 0;
	logic [OUT_W-1:0]  m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic              m_tlast;
	logic              psel = 0;
	logic              penable = 0;
	logic              pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	pair_event_scoreboard tracker_sb = new();

	// idle percentages of sender and receiver, changed per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	contact_pair_event_tracker uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver: check every accepted event item, then pick the next ready.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker_sb.check_result(m_tdata, m_tuser, m_tlast);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Command item as {tdata, tuser}.
	function automatic logic [IN_W+CMD_W-1:0] pack_cmd(logic [2:0] cmd, logic [9:0] a,
		logic [9:0] b, logic alive, logic fev, logic fsen);
		return {1'b0, fsen, fev, alive, b, a, cmd};
	endfunction

	// Offer one command item; idle first at random, hold until accepted.
	task automatic send_item(logic [IN_W+CMD_W-1:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d[IN_W+CMD_W-1:CMD_W];
		s_tuser <= d[CMD_W-1:0];
		do @(posedge clk); while (!s_tready);
		tracker_sb.note_item(d[IN_W+CMD_W-1:CMD_W], d[CMD_W-1:0]);
	endtask

	// Drop valid and let the block drain before touching registers.
	task automatic wait_drained();
		s_tvalid <= 0;
		@(posedge clk);
		while (tracker_sb.events_due.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		tracker_sb.set_config(addr, value);
	endtask

	// Mostly bodies from a small pool so pairs repeat and the table fills;
	// sometimes any slot so every bit toggles.
	function automatic logic [9:0] pick_body();
		if ($urandom_range(99) < 85)
			return 10'($urandom_range(14));
		return 10'($urandom_range(1023));
	endfunction

	task automatic random_phase(int n_items, bit pause_midway);
		int       r;
		logic [2:0] cmd;
		for (int k = 0; k < n_items; k++) begin
			if (pause_midway && k == n_items / 2) begin
				// hold off until every outstanding event item has come back
				s_tvalid <= 0;
				@(posedge clk);
				while (tracker_sb.events_due.size() != 0)
					@(posedge clk);
			end
			r = $urandom_range(99);
			if (r < 62)
				cmd = CMD_TOUCH;
			else if (r < 74)
				cmd = CMD_END_STEP;
			else if (r < 78)
				cmd = CMD_DISARM_ALL;
			else if (r < 83)
				cmd = CMD_DISARM_BODY;
			else if (r < 88)
				cmd = CMD_DROP_BODY;
			else if (r < 97)
				cmd = CMD_SET_FLAGS;
			else
				cmd = 3'(6 + $urandom_range(1));
			send_item(pack_cmd(cmd, pick_body(), pick_body(), $urandom_range(99) < 92,
				$urandom_range(99) < 75, 1'($urandom_range(1))));
		end
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Directed: begin, stay, extremes, dead pair, gating, sensors, ends.
		write_reg(ADDR_EVENTS_ENABLED, 32'd1);
		write_reg(ADDR_LISTENER_PRESENT, 32'd1);
		send_item(pack_cmd(CMD_TOUCH, 10'd0, 10'd1, 1, 0, 0));
		send_item(pack_cmd(CMD_TOUCH, 10'd1, 10'd0, 1, 0, 0));
		send_item(pack_cmd(CMD_TOUCH, 10'd1023, 10'd1023, 1, 0, 0));
		send_item(pack_cmd(CMD_TOUCH, 10'd3, 10'd4, 0, 1, 1));
		send_item(pack_cmd(CMD_SET_FLAGS, 10'd1023, 10'd0, 0, 0, 1));
		send_item(pack_cmd(CMD_TOUCH, 10'd1023, 10'd5, 1, 0, 0));
		send_item(pack_cmd(CMD_SET_FLAGS, 10'd7, 10'd1023, 1, 1, 1));
		send_item(pack_cmd(CMD_TOUCH, 10'd7, 10'd3, 1, 0, 0));
		send_item(pack_cmd(CMD_END_STEP, 10'd0, 10'd0, 0, 0, 0));
		send_item(pack_cmd(CMD_END_STEP, 10'd0, 10'd0, 0, 0, 0));
		send_item(pack_cmd(CMD_TOUCH, 10'd2, 10'd9, 1, 0, 0));
		send_item(pack_cmd(CMD_TOUCH, 10'd9, 10'd8, 1, 0, 0));
		send_item(pack_cmd(CMD_END_STEP, 10'd0, 10'd0, 0, 0, 0));
		send_item(pack_cmd(CMD_DISARM_ALL, 10'd0, 10'd0, 0, 0, 0));
		send_item(pack_cmd(CMD_TOUCH, 10'd2, 10'd9, 1, 0, 0));
		send_item(pack_cmd(CMD_DISARM_BODY, 10'd9, 10'd0, 0, 0, 0));
		send_item(pack_cmd(CMD_DROP_BODY, 10'd8, 10'd0, 0, 0, 0));
		send_item(pack_cmd(3'd6, 10'd1023, 10'd1023, 1, 1, 1));
		send_item(pack_cmd(3'd7, 10'd0, 10'd0, 1, 1, 1));
		send_item(pack_cmd(CMD_SET_FLAGS, 10'd1023, 10'd0, 0, 1, 0));
		send_item(pack_cmd(CMD_END_STEP, 10'd0, 10'd0, 0, 0, 0));
		send_item(pack_cmd(CMD_END_STEP, 10'd0, 10'd0, 0, 0, 0));
		wait_drained();

		// Random phases across register settings and idling patterns.
		send_idle_pct = 19;
		recv_idle_pct = 68;
		random_phase(100, 1);
		write_reg(ADDR_EVENTS_ENABLED, 32'd0);
		random_phase(90, 0);
		send_idle_pct = 68;
		recv_idle_pct = 19;
		write_reg(ADDR_EVENTS_ENABLED, 32'd1);
		write_reg(ADDR_LISTENER_PRESENT, 32'd0);
		random_phase(90, 0);
		write_reg(ADDR_EVENTS_ENABLED, 32'd0);
		random_phase(60, 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(ADDR_EVENTS_ENABLED, 32'd1);
		write_reg(ADDR_LISTENER_PRESENT, 32'd1);
		random_phase(160, 0);

		if (tracker_sb.errors == 0 && tracker_sb.events_due.size() == 0) begin
			$display("contact_pair_event_tracker test passed");
		end else begin
			if (tracker_sb.events_due.size() != 0)
				$error("%0d event items never arrived", tracker_sb.events_due.size());
			$display("contact_pair_event_tracker test failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#200ms;
		$display("contact_pair_event_tracker test failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cpet_pkg.sv
hdl/cpet_ram.sv
hdl/contact_pair_event_tracker.sv
test/tb_top.sv
